// ===== rtl/ldwb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldwb_pkg
// Shared types, constants and fixed-point helpers for the leapfrog wall
// bounce pipeline.
// ----------------------------------------------------------------------------
package ldwb_pkg;

	localparam int MAX_BOUNCES    = 4;
	localparam int N_AXES         = 3;
	localparam int WALLS_PER_PASS = 2 * N_AXES;
	localparam int N_WALLS        = MAX_BOUNCES * WALLS_PER_PASS;

	typedef logic [31:0]               word_t;
	typedef word_t [N_AXES-1:0]        vec3_t;
	typedef logic signed [50:0]        prod_t;
	typedef logic signed [34:0]        rnd_t;

	typedef enum logic [2:0] {
		REG_X_MIN,
		REG_X_MAX,
		REG_Y_MIN,
		REG_Y_MAX,
		REG_Z_MIN,
		REG_Z_MAX,
		REG_TIME_STEP,
		REG_DAMPING
	} reg_idx_t;

	localparam word_t       WALL_MIN_RESET = 32'd0;
	localparam word_t       WALL_MAX_RESET = 32'd655360;
	localparam logic [15:0] DT_RESET       = 16'd655;
	localparam logic [15:0] DAMP_RESET     = 16'd39322;

	// particle as it travels down the pipe
	typedef struct packed {
		vec3_t p;
		vec3_t v;
		vec3_t mean;
		logic  active;
		logic  clamped;
	} part_t;

	typedef struct packed {
		vec3_t       lo;
		vec3_t       hi;
		logic [15:0] dt;
		logic [15:0] damp;
	} cfg_t;

	// Q16 product back to Q16.16, round half up (floor of p + 2^15)
	function automatic rnd_t rnd_q16(input prod_t x);
		prod_t t;
		prod_t s;
		t = x + prod_t'(32768);
		s = t >>> 16;
		return s[34:0];
	endfunction

	function automatic word_t sat32(input logic signed [35:0] x);
		word_t r;
		if (x > 36'sh07FFFFFFF)
			r = 32'h7FFFFFFF;
		else if (x < 36'shF80000000)
			r = 32'h80000000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/ldwb_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldwb_step
// Four-stage leapfrog update: velocity by acc*dt, position by v*dt, mean
// velocity of old and new.
// ----------------------------------------------------------------------------
module ldwb_step import ldwb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  vec3_t       pos,
	input  vec3_t       hv,
	input  vec3_t       acc,
	input  logic [15:0] dt,
	output logic        out_vld,
	output part_t       out_part
);

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	vec3_t                    pos_s1, pos_s2, pos_s3;
	vec3_t                    old_s1, old_s2, old_s3;
	prod_t [N_AXES-1:0]       pa_s1;
	vec3_t                    v_s2, v_s3;
	prod_t [N_AXES-1:0]       pv_s3;
	part_t                    part_s4;

	prod_t [N_AXES-1:0]       pa, pv;
	vec3_t                    v_new;
	rnd_t  [N_AXES-1:0]       ra, rp;
	part_t                    part_new;
	logic [32:0]              msum [N_AXES];

	always_comb begin
		for (int i = 0; i < N_AXES; i++) begin
			pa[i] = $signed(acc[i]) * $signed({1'b0, dt});
			ra[i] = rnd_q16(pa_s1[i]);
			v_new[i] = sat32({{4{old_s1[i][31]}}, old_s1[i]} + {ra[i][34], ra[i]});
			pv[i] = $signed(v_s2[i]) * $signed({1'b0, dt});
			rp[i] = rnd_q16(pv_s3[i]);
			msum[i] = {old_s3[i][31], old_s3[i]} + {v_s3[i][31], v_s3[i]};
		end
		part_new = '0;
		for (int i = 0; i < N_AXES; i++) begin
			part_new.p[i] = sat32({{4{pos_s3[i][31]}}, pos_s3[i]} + {rp[i][34], rp[i]});
			part_new.v[i] = v_s3[i];
			part_new.mean[i] = msum[i][32:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1  <= pos;
			old_s1  <= hv;
			pa_s1   <= pa;
			pos_s2  <= pos_s1;
			old_s2  <= old_s1;
			v_s2    <= v_new;
			pos_s3  <= pos_s2;
			old_s3  <= old_s2;
			v_s3    <= v_s2;
			pv_s3   <= pv;
			part_s4 <= part_new;
		end
	end

	assign out_vld  = vld_s4;
	assign out_part = part_s4;

endmodule

// ===== rtl/ldwb_wall.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldwb_wall
// One wall test and damped reflection, two stages: products, then round,
// add and saturate.
// ----------------------------------------------------------------------------
module ldwb_wall import ldwb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  part_t       in_part,
	input  logic [1:0]  axis,
	input  logic        upper,
	input  word_t       bound,
	input  logic [15:0] damp,
	output logic        out_vld,
	output part_t       out_part
);

	logic signed [31:0]  pi;
	logic                hit;
	logic signed [33:0]  over;
	vec3_t               vadj;
	prod_t [N_AXES-1:0]  vprod;
	prod_t               oprod;

	logic                vld_s1, vld_s2;
	logic                hit_s1;
	part_t               part_s1, part_s2;
	prod_t [N_AXES-1:0]  vprod_s1;
	prod_t               oprod_s1;

	rnd_t  [N_AXES-1:0]  rv;
	rnd_t                ro;
	logic signed [35:0]  bx, rx, pnew;
	part_t               nxt;

	always_comb begin
		pi   = $signed(in_part.p[axis]);
		hit  = in_part.active && (upper ? (pi > $signed(bound)) : (pi < $signed(bound)));
		over = upper ? ({pi[31], pi[31], pi} - {bound[31], bound[31], bound})
		             : ({bound[31], bound[31], bound} - {pi[31], pi[31], pi});
		vadj = in_part.v;
		if (hit) begin
			// turn the component inward; -(-2^31) saturates
			if (upper && !in_part.v[axis][31])
				vadj[axis] = -in_part.v[axis];
			else if (!upper && in_part.v[axis][31])
				vadj[axis] = (in_part.v[axis] == 32'h80000000) ? 32'h7FFFFFFF
				                                               : -in_part.v[axis];
		end
		for (int j = 0; j < N_AXES; j++)
			vprod[j] = $signed(vadj[j]) * $signed({1'b0, damp});
		oprod = over * $signed({1'b0, damp});
	end

	always_comb begin
		nxt = part_s1;
		for (int j = 0; j < N_AXES; j++)
			rv[j] = rnd_q16(vprod_s1[j]);
		ro   = rnd_q16(oprod_s1);
		bx   = {{4{bound[31]}}, bound};
		rx   = {ro[34], ro};
		pnew = upper ? (bx - rx) : (bx + rx);
		if (hit_s1) begin
			for (int j = 0; j < N_AXES; j++)
				nxt.v[j] = sat32({rv[j][34], rv[j]});
			nxt.p[axis] = sat32(pnew);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1   <= hit;
			part_s1  <= in_part;
			vprod_s1 <= vprod;
			oprod_s1 <= oprod;
			part_s2  <= nxt;
		end
	end

	assign out_vld  = vld_s2;
	assign out_part = part_s2;

endmodule

// ===== rtl/leapfrog_damped_wall_bounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leapfrog_damped_wall_bounce
// Leapfrog step of one particle per request, with damped reflection off an
// axis-aligned box and a clamp after the last bounce pass.
// ----------------------------------------------------------------------------
// Pipeline: the leapfrog front end, then in each pass one box test stage and
// six two-stage walls, then the clamp stage that registers the result.
// Throughput: one request per cycle; a stalled result halts the whole pipe.
// Reset: arst_n clears the valid bits and loads the box 0..10.0 on each axis,
// dt = 655 and damping = 39322. No clearing pass.
module leapfrog_damped_wall_bounce import ldwb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] half_vel_x,
	input  logic [31:0] half_vel_y,
	input  logic [31:0] half_vel_z,
	input  logic [31:0] acc_x,
	input  logic [31:0] acc_y,
	input  logic [31:0] acc_z,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] new_pos_x,
	output logic [31:0] new_pos_y,
	output logic [31:0] new_pos_z,
	output logic [31:0] new_half_vel_x,
	output logic [31:0] new_half_vel_y,
	output logic [31:0] new_half_vel_z,
	output logic [31:0] mean_vel_x,
	output logic [31:0] mean_vel_y,
	output logic [31:0] mean_vel_z,
	output logic        clamped
);

	function automatic logic outside(input vec3_t p, input vec3_t lo, input vec3_t hi);
		logic o;
		o = 1'b0;
		for (int i = 0; i < N_AXES; i++)
			o = o | ($signed(p[i]) < $signed(lo[i])) | ($signed(p[i]) > $signed(hi[i]));
		return o;
	endfunction

	// --- configuration registers ---------------------------------------------
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lo   <= {N_AXES{WALL_MIN_RESET}};
			cfg_q.hi   <= {N_AXES{WALL_MAX_RESET}};
			cfg_q.dt   <= DT_RESET;
			cfg_q.damp <= DAMP_RESET;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_X_MIN:     cfg_q.lo[0] <= cfg_data;
				REG_X_MAX:     cfg_q.hi[0] <= cfg_data;
				REG_Y_MIN:     cfg_q.lo[1] <= cfg_data;
				REG_Y_MAX:     cfg_q.hi[1] <= cfg_data;
				REG_Z_MIN:     cfg_q.lo[2] <= cfg_data;
				REG_Z_MAX:     cfg_q.hi[2] <= cfg_data;
				REG_TIME_STEP: cfg_q.dt    <= cfg_data[15:0];
				REG_DAMPING:   cfg_q.damp  <= cfg_data[15:0];
				default:       cfg_q       <= cfg_q;
			endcase
		end
	end

	// --- pipeline advance: everything moves unless the result is held ------
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// --- leapfrog front end (4 stages) ---------------------------------------
	logic  front_vld;
	part_t front_part;

	ldwb_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.pos      ({pos_z, pos_y, pos_x}),
		.hv       ({half_vel_z, half_vel_y, half_vel_x}),
		.acc      ({acc_z, acc_y, acc_x}),
		.dt       (cfg_q.dt),
		.out_vld  (front_vld),
		.out_part (front_part)
	);

	// --- bounce passes --------------------------------------------------------
	// Each pass opens with a box test; a particle already inside goes through
	// the walls untouched, which matches stopping the loop early since the
	// position no longer changes.
	part_t chk_s     [MAX_BOUNCES];
	logic  chk_vld_s [MAX_BOUNCES];
	part_t wall_part [N_WALLS];
	logic  wall_vld  [N_WALLS];

	for (genvar g = 0; g < MAX_BOUNCES; g++) begin : g_pass
		part_t src;
		logic  src_vld;
		part_t chk_d;

		if (g == 0) begin : g_first
			assign src     = front_part;
			assign src_vld = front_vld;
		end else begin : g_next
			assign src     = wall_part[g*WALLS_PER_PASS-1];
			assign src_vld = wall_vld[g*WALLS_PER_PASS-1];
		end

		always_comb begin
			chk_d        = src;
			chk_d.active = outside(src.p, cfg_q.lo, cfg_q.hi);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				chk_vld_s[g] <= 1'b0;
			else if (en)
				chk_vld_s[g] <= src_vld;
		end

		always_ff @(posedge clk) begin
			if (en)
				chk_s[g] <= chk_d;
		end
	end

	// lower walls x, y, z then upper walls x, y, z in every pass
	for (genvar w = 0; w < N_WALLS; w++) begin : g_wall
		localparam int K = w % WALLS_PER_PASS;
		localparam int A = K % N_AXES;
		localparam logic UP = (K >= N_AXES);
		part_t wsrc;
		logic  wsrc_vld;

		if (K == 0) begin : g_head
			assign wsrc     = chk_s[w/WALLS_PER_PASS];
			assign wsrc_vld = chk_vld_s[w/WALLS_PER_PASS];
		end else begin : g_chain
			assign wsrc     = wall_part[w-1];
			assign wsrc_vld = wall_vld[w-1];
		end

		ldwb_wall u_wall (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (wsrc_vld),
			.in_part  (wsrc),
			.axis     (2'(A)),
			.upper    (UP),
			.bound    (UP ? cfg_q.hi[A] : cfg_q.lo[A]),
			.damp     (cfg_q.damp),
			.out_vld  (wall_vld[w]),
			.out_part (wall_part[w])
		);
	end

	// --- final clamp, doubles as the output register --------------------------
	// Lower wall first, then upper: an inverted box lands on max.
	part_t fin_in, fin_s;
	logic  fin_vld_s;
	logic  fin_out;

	always_comb begin
		fin_in  = wall_part[N_WALLS-1];
		fin_out = outside(fin_in.p, cfg_q.lo, cfg_q.hi);
		fin_in.clamped = fin_out;
		if (fin_out) begin
			for (int i = 0; i < N_AXES; i++) begin
				if ($signed(fin_in.p[i]) < $signed(cfg_q.lo[i]))
					fin_in.p[i] = cfg_q.lo[i];
				if ($signed(fin_in.p[i]) > $signed(cfg_q.hi[i]))
					fin_in.p[i] = cfg_q.hi[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fin_vld_s <= 1'b0;
		else if (en)
			fin_vld_s <= wall_vld[N_WALLS-1];
	end

	always_ff @(posedge clk) begin
		if (en)
			fin_s <= fin_in;
	end

	assign out_valid      = fin_vld_s;
	assign new_pos_x      = fin_s.p[0];
	assign new_pos_y      = fin_s.p[1];
	assign new_pos_z      = fin_s.p[2];
	assign new_half_vel_x = fin_s.v[0];
	assign new_half_vel_y = fin_s.v[1];
	assign new_half_vel_z = fin_s.v[2];
	assign mean_vel_x     = fin_s.mean[0];
	assign mean_vel_y     = fin_s.mean[1];
	assign mean_vel_z     = fin_s.mean[2];
	assign clamped        = fin_s.clamped;

	// --- assertions -----------------------------------------------------------
	// clamp ends on or below the upper wall on every axis
	a_clamp_hi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |->
			$signed(new_pos_x) <= $signed(cfg_q.hi[0]) &&
			$signed(new_pos_y) <= $signed(cfg_q.hi[1]) &&
			$signed(new_pos_z) <= $signed(cfg_q.hi[2]))
		else $error("clamped result above upper wall");

	// an unclamped result lies inside the box
	a_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !clamped |-> !outside(fin_s.p, cfg_q.lo, cfg_q.hi))
		else $error("unclamped result outside box");

	// input is refused only while a result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without output stall");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - leapfrog_damped_wall_bounce testbench
// Drives particles through the leapfrog step with box reflection, predicts
// each result with a behavioural model of the bounce passes and compares all
// fields in order. Walls, dt and damping are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb;
	import ldwb_pkg::*;

	localparam int LATENCY = 4 + 13 * MAX_BOUNCES + 1;

	typedef struct {
		logic [31:0] p [3];
		logic [31:0] v [3];
		logic [31:0] a [3];
	} particle_t;

	typedef struct {
		logic [31:0] p [3];
		logic [31:0] v [3];
		logic [31:0] m [3];
		logic        clamped;
	} motion_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [31:0] half_vel_x = '0, half_vel_y = '0, half_vel_z = '0;
	logic [31:0] acc_x = '0, acc_y = '0, acc_z = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] new_pos_x, new_pos_y, new_pos_z;
	logic [31:0] new_half_vel_x, new_half_vel_y, new_half_vel_z;
	logic [31:0] mean_vel_x, mean_vel_y, mean_vel_z;
	logic        clamped;

	leapfrog_damped_wall_bounce i_dut (.*);

	// predictor copy of the registers
	longint     wall_lo [3];
	longint     wall_hi [3];
	longint     dt_q;
	longint     damp_q;

	particle_t  pending_parts [$];
	motion_t    expected_motion [$];
	int         mismatches = 0;
	int         results_seen = 0;
	int         bounced_seen = 0;
	int         clamps_seen = 0;
	bit         hold_sink = 1'b0;
	bit         stimulus_done = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint sat_word(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// round half up of a Q16 product: arithmetic shift is a floor
	function automatic longint scale_q16(longint a, longint f);
		return (a * f + 32768) >>> 16;
	endfunction

	function automatic bit out_of_box(longint p [3]);
		for (int i = 0; i < 3; i++)
			if (p[i] < wall_lo[i] || p[i] > wall_hi[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic motion_t step_particle(particle_t q);
		motion_t r;
		longint  p [3];
		longint  v [3];
		longint  over;
		longint  v_old;
		r.clamped = 1'b0;
		for (int i = 0; i < 3; i++) begin
			v_old = longint'(signed'(q.v[i]));
			v[i] = sat_word(v_old + scale_q16(longint'(signed'(q.a[i])), dt_q));
			p[i] = sat_word(longint'(signed'(q.p[i])) + scale_q16(v[i], dt_q));
			r.m[i] = 32'((v_old + v[i]) >>> 1);
		end
		for (int pass = 0; pass < MAX_BOUNCES && out_of_box(p); pass++) begin
			for (int i = 0; i < 3; i++)
				if (p[i] < wall_lo[i]) begin
					over = wall_lo[i] - p[i];
					if (v[i] < 0)
						v[i] = sat_word(-v[i]);
					for (int j = 0; j < 3; j++)
						v[j] = sat_word(scale_q16(v[j], damp_q));
					p[i] = sat_word(wall_lo[i] + scale_q16(over, damp_q));
				end
			for (int i = 0; i < 3; i++)
				if (p[i] > wall_hi[i]) begin
					over = p[i] - wall_hi[i];
					if (v[i] > 0)
						v[i] = -v[i];
					for (int j = 0; j < 3; j++)
						v[j] = sat_word(scale_q16(v[j], damp_q));
					p[i] = sat_word(wall_hi[i] - scale_q16(over, damp_q));
				end
		end
		// clamp: lower wall first, so an inverted box ends at its max
		if (out_of_box(p)) begin
			r.clamped = 1'b1;
			for (int i = 0; i < 3; i++) begin
				if (p[i] < wall_lo[i])
					p[i] = wall_lo[i];
				if (p[i] > wall_hi[i])
					p[i] = wall_hi[i];
			end
		end
		for (int i = 0; i < 3; i++) begin
			r.p[i] = 32'(p[i]);
			r.v[i] = 32'(v[i]);
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'(int'($urandom_range(2000)) - 1000);
			3, 4: return $urandom;
			default: return 32'(int'($urandom_range(24 << 16)) - (7 << 16));
		endcase
	endfunction

	function automatic particle_t rand_particle();
		particle_t q;
		for (int i = 0; i < 3; i++) begin
			q.p[i] = rand_word();
			q.v[i] = rand_word();
			q.a[i] = rand_word();
			// mostly near the box so bounces dominate
			if ($urandom_range(3) != 0) begin
				q.p[i] = 32'(int'($urandom_range(16 << 16)) - (3 << 16));
				q.v[i] = 32'(int'($urandom_range(400 << 16)) - (200 << 16));
			end
		end
		return q;
	endfunction

	function automatic particle_t mk_particle(logic [31:0] p, logic [31:0] v, logic [31:0] a);
		particle_t q;
		for (int i = 0; i < 3; i++) begin
			q.p[i] = p;
			q.v[i] = v;
			q.a[i] = a;
		end
		return q;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(9) < 5)
			return 0;
		if ($urandom_range(19) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	// driver: pops particles, random gaps between requests
	int src_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_motion.push_back(step_particle(pending_parts.pop_front()));
				src_gap = gap_len();
			end
			if ((!in_valid || in_ready) && src_gap > 0) begin
				in_valid <= 1'b0;
				src_gap--;
			end else if (!in_valid || in_ready) begin
				if (pending_parts.size() != 0) begin
					in_valid   <= 1'b1;
					pos_x      <= pending_parts[0].p[0];
					pos_y      <= pending_parts[0].p[1];
					pos_z      <= pending_parts[0].p[2];
					half_vel_x <= pending_parts[0].v[0];
					half_vel_y <= pending_parts[0].v[1];
					half_vel_z <= pending_parts[0].v[2];
					acc_x      <= pending_parts[0].a[0];
					acc_y      <= pending_parts[0].a[1];
					acc_z      <= pending_parts[0].a[2];
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor and sink stall
	int sink_gap = 0;
	always @(posedge clk) begin
		motion_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_motion.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result at %0t", $realtime);
				end else begin
					e = expected_motion.pop_front();
					if ({new_pos_x, new_pos_y, new_pos_z, new_half_vel_x, new_half_vel_y,
					     new_half_vel_z, mean_vel_x, mean_vel_y, mean_vel_z, clamped} !==
					    {e.p[0], e.p[1], e.p[2], e.v[0], e.v[1], e.v[2],
					     e.m[0], e.m[1], e.m[2], e.clamped}) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch %0d: pos %h %h %h vel %h %h %h", results_seen,
							         new_pos_x, new_pos_y, new_pos_z,
							         new_half_vel_x, new_half_vel_y, new_half_vel_z);
							$display("  mean %h %h %h clamp %b", mean_vel_x, mean_vel_y,
							         mean_vel_z, clamped);
							$display("  exp pos %h %h %h vel %h %h %h", e.p[0], e.p[1], e.p[2],
							         e.v[0], e.v[1], e.v[2]);
							$display("  exp mean %h %h %h clamp %b", e.m[0], e.m[1], e.m[2],
							         e.clamped);
						end
					end
					if (e.clamped)
						clamps_seen++;
					if (e.v[0] != 32'(0) && e.p[0] inside {32'(wall_lo[0]), 32'(wall_hi[0])})
						bounced_seen++;
				end
			end
			if (hold_sink)
				out_ready <= 1'b0;
			else if (sink_gap > 0) begin
				out_ready <= 1'b0;
				sink_gap--;
			end else begin
				out_ready <= 1'b1;
				sink_gap = gap_len();
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_X_MIN, REG_Y_MIN, REG_Z_MIN: wall_lo[int'(idx) >> 1] = longint'(signed'(data));
			REG_X_MAX, REG_Y_MAX, REG_Z_MAX: wall_hi[int'(idx) >> 1] = longint'(signed'(data));
			REG_TIME_STEP: dt_q = data[15:0];
			REG_DAMPING: damp_q = data[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (pending_parts.size() == 0 && !in_valid);
		wait (expected_motion.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_box(logic [31:0] lo, logic [31:0] hi, logic [15:0] dt,
	                       logic [15:0] damp);
		write_reg(REG_X_MIN, lo);
		write_reg(REG_X_MAX, hi);
		write_reg(REG_Y_MIN, lo);
		write_reg(REG_Y_MAX, hi);
		write_reg(REG_Z_MIN, lo);
		write_reg(REG_Z_MAX, hi);
		write_reg(REG_TIME_STEP, 32'(dt));
		write_reg(REG_DAMPING, 32'(damp));
	endtask

	initial begin
		for (int i = 0; i < 3; i++) begin
			wall_lo[i] = longint'(signed'(WALL_MIN_RESET));
			wall_hi[i] = longint'(signed'(WALL_MAX_RESET));
		end
		dt_q = DT_RESET;
		damp_q = DAMP_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, extremes, zero velocity, deep overshoot
		pending_parts.push_back(mk_particle(32'h00050000, 32'h0, 32'h0));
		pending_parts.push_back(mk_particle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		pending_parts.push_back(mk_particle(32'h80000000, 32'h80000000, 32'h80000000));
		pending_parts.push_back(mk_particle(32'hFFFFFFFF, 32'h0, 32'h0));
		pending_parts.push_back(mk_particle(32'h000A0001, 32'h0, 32'h0));
		pending_parts.push_back(mk_particle(32'h00140000, 32'h00640000, 32'h0));
		pending_parts.push_back(mk_particle(32'hFFF00000, 32'hFF9C0000, 32'hFF000000));
		pending_parts.push_back(mk_particle(32'h00000000, 32'h80000000, 32'h0));
		drain();

		// full dt, zero damping; in the unit box it lands on the wall, velocity zero
		set_box(32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 16'h0000);
		for (int k = 0; k < 4; k++)
			pending_parts.push_back(mk_particle(k[0] ? 32'h7FFFFFFF : 32'h80000000,
			                                    k[1] ? 32'h7FFFFFFF : 32'h80000000,
			                                    32'h7FFFFFFF));
		drain();
		set_box(32'h00000000, 32'h00010000, 16'hFFFF, 16'h0000);
		pending_parts.push_back(mk_particle(32'h00050000, 32'h00030000, 32'h0));
		pending_parts.push_back(mk_particle(32'hFFFB0000, 32'hFFFD0000, 32'h0));
		drain();
		// inverted box, full damping
		set_box(32'h00080000, 32'h00020000, 16'd655, 16'hFFFF);
		pending_parts.push_back(mk_particle(32'h00050000, 32'h00010000, 32'h0));
		pending_parts.push_back(mk_particle(32'h00000000, 32'hFFFF0000, 32'h0));
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_box(32'h0, 32'h000A0000, 16'd655, 16'd39322);
				1: set_box(32'hFFFE0000, 32'h00040000, 16'd6553, 16'd52000);
				2: set_box(32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF);
				3: set_box(32'h00000000, 32'h00000000, 16'd1, 16'd0);
				4: set_box(32'h00060000, 32'h00010000, 16'd30000, 16'd20000);
				default: begin
					write_reg(REG_X_MIN, rand_word());
					write_reg(REG_X_MAX, 32'h000C0000);
					write_reg(REG_Y_MIN, 32'hFFFF0000);
					write_reg(REG_Y_MAX, rand_word());
					write_reg(REG_Z_MIN, 32'h0);
					write_reg(REG_Z_MAX, 32'h00080000);
					write_reg(REG_TIME_STEP, $urandom);
					write_reg(REG_DAMPING, $urandom);
				end
			endcase
			for (int n = 0; n < 280; n++)
				pending_parts.push_back(rand_particle());
			if (ph == 2) begin
				// long sink hold while the source keeps offering
				hold_sink = 1'b1;
				repeat (LATENCY * 3) @(posedge clk);
				hold_sink = 1'b0;
			end
			drain();
		end
		stimulus_done = 1'b1;
	end

	initial begin
		wait (stimulus_done);
		$display("covered %0d particles, %0d clamped, %0d wall landings, over ten settings",
		         results_seen, clamps_seen, bounced_seen);
		if (mismatches == 0 && expected_motion.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("tb NOT OK");
		$finish;
	end

endmodule
